// ===== src/itt_pkg.sv =====
// itt_pkg: shared codes and byte constants for the indent tree tokenizer
// no dependencies; imported by indent_tree_tokenizer_core
`default_nettype none

package itt_pkg;

	typedef enum logic [1:0] {
		KIND_TOKEN     = 2'd0,
		KIND_DONE      = 2'd1,
		KIND_NO_TOKENS = 2'd2,
		KIND_TOO_DEEP  = 2'd3
	} record_kind_t;

	typedef enum logic [1:0] {
		TYPE_SECTION = 2'd0,
		TYPE_KEY     = 2'd1,
		TYPE_VALUE   = 2'd2
	} token_type_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam int unsigned LIMIT_W = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

endpackage

`default_nettype wire

// ===== src/indent_tree_tokenizer_core.sv =====
// indent_tree_tokenizer_core: byte stream to section/key/value token records
// depends on itt_pkg (codes, byte constants)
// dataflow: a byte is taken into the input register, its records go into the result register
//   once that is free, and leave one per cycle on the master side while m_tready is high
// throughput: one byte per cycle while each byte gives at most one record and m_tready
//   stays high; a byte that gives several records (up to 3) holds the slave side until the
//   single result port has drained them, one record per transaction
// reset: asynchronous, clears all tokenizer state and the level table, token limit 65535
`default_nettype none

module indent_tree_tokenizer_core #(
	parameter int unsigned INDENT_LEVELS = 10,
	parameter int unsigned INDEX_BITS    = 16,
	parameter int unsigned POSITION_BITS = 16,
	localparam int unsigned DATA_BITS = 2 * INDEX_BITS + 2 * POSITION_BITS + 3,
	localparam int unsigned TDATA_W   = ((DATA_BITS + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// slave side, tdata: doc_byte
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,
	// master side
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// tdata: token_index, token_type, start_pos, end_pos, parent_index, zero pad
	output logic [TDATA_W-1:0]               m_tdata,
	// tuser: record_kind
	output itt_pkg::record_kind_t            m_tuser,
	output logic                             m_tlast,
	input  wire logic                        cfg_we,
	input  wire logic [itt_pkg::LIMIT_W-1:0] cfg_wdata
);
	import itt_pkg::*;

	localparam int unsigned TAB_W = $clog2(INDENT_LEVELS + 1);
	localparam int unsigned LVL_W = $clog2(INDENT_LEVELS);
	localparam int unsigned END_W = POSITION_BITS + 1;
	localparam int unsigned CMP_W = (INDEX_BITS > LIMIT_W) ? INDEX_BITS : LIMIT_W;
	localparam logic [TAB_W-1:0] TAB_MAX = TAB_W'(INDENT_LEVELS);

	typedef struct packed {
		record_kind_t              kind;
		logic [INDEX_BITS-1:0]     idx;
		token_type_t               typ;
		logic [POSITION_BITS-1:0]  start;
		logic signed [END_W-1:0]   end_pos;
		logic [INDEX_BITS-1:0]     parent;
	} rec_t;

	// architectural state
	logic [LIMIT_W-1:0]       limit_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [INDEX_BITS-1:0]    idx_q;
	token_type_t              type_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [INDEX_BITS-1:0]    par_q;
	logic [INDEX_BITS-1:0]    lnv_q;
	logic signed [END_W-1:0]  lpc_q;
	logic [TAB_W-1:0]         tabs_q;
	logic                     sep_q;
	logic                     stop_q;
	logic [INDEX_BITS-1:0]    lvl_q [INDENT_LEVELS];

	// pipeline
	logic       valid_s1;
	logic [7:0] byte_s1;
	rec_t       rec_s2 [3];
	logic [1:0] cnt_s2;
	logic [1:0] ptr_s2;

	// next state from the byte in the input register
	logic [POSITION_BITS-1:0] pos_d;
	logic [INDEX_BITS-1:0]    idx_d;
	token_type_t              type_d;
	logic [POSITION_BITS-1:0] start_d;
	logic [INDEX_BITS-1:0]    par_d;
	logic [INDEX_BITS-1:0]    lnv_d;
	logic signed [END_W-1:0]  lpc_d;
	logic [TAB_W-1:0]         tabs_d;
	logic                     sep_d;
	logic                     stop_d;
	logic                     lvl_we;
	logic [LVL_W-1:0]         lvl_wa;
	logic [INDEX_BITS-1:0]    lvl_wd;
	rec_t                     rec_d [3];
	logic [1:0]               rec_n;

	logic out_fire;
	logic s2_free;
	logic advance;

	function automatic rec_t term_rec(record_kind_t kind, logic [INDEX_BITS-1:0] idx);
		rec_t r;
		r         = '0;
		r.kind    = kind;
		r.idx     = idx;
		r.typ     = TYPE_SECTION;
		return r;
	endfunction

	function automatic logic at_limit(logic [INDEX_BITS-1:0] idx, logic [LIMIT_W-1:0] lim);
		return CMP_W'(idx) >= CMP_W'(lim);
	endfunction

	always_comb begin
		logic                     halt;
		logic [INDEX_BITS-1:0]    fresh;
		logic signed [END_W-1:0]  pos_m1;
		logic [TAB_W-1:0]         cnt;
		pos_d   = pos_q;
		idx_d   = idx_q;
		type_d  = type_q;
		start_d = start_q;
		par_d   = par_q;
		lnv_d   = lnv_q;
		lpc_d   = lpc_q;
		tabs_d  = tabs_q;
		sep_d   = sep_q;
		stop_d  = stop_q;
		lvl_we  = 1'b0;
		lvl_wa  = tabs_q[LVL_W-1:0];
		lvl_wd  = idx_q + 1'b1;
		rec_n   = 2'd0;
		halt    = 1'b0;
		fresh   = idx_q + 1'b1;
		pos_m1  = $signed({1'b0, pos_q}) - END_W'(1);
		cnt     = '0;
		for (int k = 0; k < 3; k++) begin
			rec_d[k] = term_rec(KIND_TOKEN, '0);
		end
		if (!stop_q) begin
			// resolve a pending newline/tab run before the byte itself
			if (sep_q && byte_s1 != CH_TAB) begin
				sep_d = 1'b0;
				if (tabs_q >= TAB_MAX) begin
					rec_d[rec_n] = term_rec(KIND_TOO_DEEP, idx_q);
					rec_n        = rec_n + 2'd1;
					stop_d       = 1'b1;
					halt         = 1'b1;
				end else begin
					rec_d[rec_n] = '{kind: KIND_TOKEN, idx: idx_q, typ: type_q,
						start: start_q, end_pos: lpc_q, parent: par_q};
					rec_n   = rec_n + 2'd1;
					lvl_we  = 1'b1;
					idx_d   = fresh;
					type_d  = (byte_s1 == CH_UNDER) ? TYPE_SECTION : TYPE_KEY;
					start_d = pos_q;
					// level zero is its own parent
					par_d   = (tabs_q == '0) ? fresh : lvl_q[tabs_q[LVL_W-1:0] - 1'b1];
					lnv_d   = fresh;
					if (at_limit(fresh, limit_q)) begin
						rec_d[rec_n] = term_rec(KIND_NO_TOKENS, fresh);
						rec_n        = rec_n + 2'd1;
						stop_d       = 1'b1;
						halt         = 1'b1;
					end
				end
			end
			if (!halt) begin
				if (byte_s1 == CH_TAB || byte_s1 == CH_LF) begin
					cnt = sep_q ? tabs_q : '0;
					if (byte_s1 == CH_TAB && cnt < TAB_MAX) begin
						cnt = cnt + 1'b1;
					end
					tabs_d = cnt;
					sep_d  = 1'b1;
					pos_d  = pos_q + 1'b1;
				end else if (byte_s1 == CH_NUL) begin
					rec_d[rec_n] = '{kind: KIND_TOKEN, idx: idx_d, typ: type_d,
						start: start_d, end_pos: pos_m1, parent: par_d};
					rec_n        = rec_n + 2'd1;
					rec_d[rec_n] = term_rec(at_limit(idx_d, limit_q) ? KIND_NO_TOKENS
						: KIND_DONE, idx_d);
					rec_n        = rec_n + 2'd1;
					stop_d       = 1'b1;
				end else begin
					lpc_d = $signed({1'b0, pos_q});
					if (byte_s1 == CH_SPACE) begin
						rec_d[rec_n] = '{kind: KIND_TOKEN, idx: idx_d, typ: type_d,
							start: start_d, end_pos: pos_m1, parent: par_d};
						rec_n   = rec_n + 2'd1;
						idx_d   = idx_d + 1'b1;
						type_d  = TYPE_VALUE;
						start_d = pos_q + 1'b1;
						par_d   = lnv_d;
					end
					if (at_limit(idx_d, limit_q)) begin
						rec_d[rec_n] = term_rec(KIND_NO_TOKENS, idx_d);
						rec_n        = rec_n + 2'd1;
						stop_d       = 1'b1;
					end else begin
						pos_d = pos_q + 1'b1;
					end
				end
			end
		end
	end

	assign out_fire = m_tvalid && m_tready;
	assign s2_free  = (cnt_s2 == 2'd0) || (out_fire && ptr_s2 == cnt_s2 - 2'd1);
	assign advance  = valid_s1 && (rec_n == 2'd0 || s2_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			idx_q   <= '0;
			type_q  <= TYPE_SECTION;
			start_q <= '0;
			par_q   <= '0;
			lnv_q   <= '0;
			lpc_q   <= '1;
			tabs_q  <= '0;
			sep_q   <= 1'b0;
			stop_q  <= 1'b0;
			for (int k = 0; k < INDENT_LEVELS; k++) begin
				lvl_q[k] <= '0;
			end
		end else if (advance) begin
			pos_q   <= pos_d;
			idx_q   <= idx_d;
			type_q  <= type_d;
			start_q <= start_d;
			par_q   <= par_d;
			lnv_q   <= lnv_d;
			lpc_q   <= lpc_d;
			tabs_q  <= tabs_d;
			sep_q   <= sep_d;
			stop_q  <= stop_d;
			if (lvl_we) begin
				lvl_q[lvl_wa] <= lvl_wd;
			end
		end
	end

	// result buffer: up to three records per byte, drained in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
			ptr_s2 <= 2'd0;
		end else if (advance && rec_n != 2'd0) begin
			cnt_s2 <= rec_n;
			ptr_s2 <= 2'd0;
		end else if (out_fire) begin
			if (ptr_s2 == cnt_s2 - 2'd1) begin
				cnt_s2 <= 2'd0;
				ptr_s2 <= 2'd0;
			end else begin
				ptr_s2 <= ptr_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rec_n != 2'd0) begin
			for (int k = 0; k < 3; k++) begin
				rec_s2[k] <= rec_d[k];
			end
		end
	end

	always_comb begin
		rec_t r;
		r        = rec_s2[ptr_s2];
		m_tvalid = cnt_s2 != 2'd0;
		m_tlast  = ptr_s2 == cnt_s2 - 2'd1;
		m_tuser  = r.kind;
		m_tdata  = TDATA_W'({r.parent, r.end_pos, r.start, r.typ, r.idx});
	end

	// a stopped tokenizer makes no records
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stop_q |-> rec_n == 2'd0)
		else $error("records produced after stop");

	// stopping always leaves a terminal record behind
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stop_q) |-> cnt_s2 != 2'd0)
		else $error("stop without a terminal record");

	// terminal records close the byte and imply the stopped state
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_TOKEN |-> m_tlast && stop_q)
		else $error("terminal record not final or not stopped");

	// tab count never passes its saturation point
	assert property (@(posedge clk) disable iff (!arst_n)
		sep_q |-> tabs_q <= TAB_MAX)
		else $error("tab count beyond saturation");

endmodule

`default_nettype wire

// ===== test/tb_indent_tree_tokenizer_core.sv =====
// testbench for indent_tree_tokenizer_core: streams documents in and checks every token record
// against a cycle-free tokenizer model kept here, under several idle and stall mixes
// depends on itt_pkg and indent_tree_tokenizer_core
`default_nettype none

module tb_indent_tree_tokenizer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import itt_pkg::*;

	localparam int unsigned DEPTH_LEVELS = 10;
	localparam int unsigned TDATA_W      = 72;
	localparam int          CYCLE_LIMIT  = 400000;

	typedef struct packed {
		record_kind_t kind;
		logic [15:0]  tok_index;
		token_type_t  tok_type;
		logic [15:0]  first_pos;
		logic [16:0]  last_pos;
		logic [15:0]  parent_idx;
		logic         is_last;
	} token_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // doc_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// token_index, token_type, start_pos, end_pos, parent_index, zero pad
	logic [TDATA_W-1:0]   m_tdata;
	record_kind_t         m_tuser;   // record_kind
	logic                 m_tlast;
	logic                 cfg_we;
	logic [LIMIT_W-1:0]   cfg_wdata;

	// tokenizer model state
	logic [15:0]  doc_pos;
	logic [15:0]  open_index;
	token_type_t  open_type;
	logic [15:0]  open_start;
	logic [15:0]  open_parent;
	logic [15:0]  last_head_index;
	logic [16:0]  last_plain_pos;
	int           tab_depth;
	bit           in_separator_run;
	logic [15:0]  level_token [DEPTH_LEVELS];
	bit           halted;
	logic [15:0]  token_cap;

	token_rec_t   step_out [3];
	int           step_count;
	token_rec_t   expected_records [$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int bytes_sent = 0;
	int records_checked = 0;
	int tokens_closed = 0;
	int fails = 0;
	int cycles = 0;
	int end_case = -1;

	indent_tree_tokenizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_record();
	end

	function automatic void reset_tokenizer_model();
		doc_pos = '0;
		open_index = '0;
		open_type = TYPE_SECTION;
		open_start = '0;
		open_parent = '0;
		last_head_index = '0;
		last_plain_pos = '1;
		tab_depth = 0;
		in_separator_run = 0;
		for (int i = 0; i < DEPTH_LEVELS; i++)
			level_token[i] = '0;
		halted = 0;
		token_cap = LIMIT_RESET;
	endfunction

	function automatic void push_rec(record_kind_t k, logic [15:0] idx, token_type_t t,
			logic [15:0] s, logic [16:0] e, logic [15:0] p);
		token_rec_t rec;
		rec.kind = k;
		rec.tok_index = idx;
		rec.tok_type = t;
		rec.first_pos = s;
		rec.last_pos = e;
		rec.parent_idx = p;
		rec.is_last = 1'b0;
		step_out[step_count] = rec;
		step_count++;
	endfunction

	function automatic void open_new_token(token_type_t t, logic [15:0] s, logic [15:0] p);
		open_index = open_index + 16'd1;
		open_type = t;
		open_start = s;
		open_parent = p;
	endfunction

	// records one document byte causes, in order
	function automatic void tokenize_byte(logic [7:0] b);
		logic [15:0] at;
		logic [15:0] fresh;
		bit was_run;
		int depth;
		step_count = 0;
		if (halted)
			return;
		at = doc_pos;
		was_run = in_separator_run;
		if (in_separator_run && b != CH_TAB) begin
			depth = tab_depth;
			in_separator_run = 0;
			if (depth >= DEPTH_LEVELS) begin
				push_rec(KIND_TOO_DEEP, open_index, TYPE_SECTION, '0, '0, '0);
				halted = 1;
				return;
			end
			push_rec(KIND_TOKEN, open_index, open_type, open_start, last_plain_pos, open_parent);
			fresh = open_index + 16'd1;
			level_token[depth] = fresh;
			open_new_token((b == CH_UNDER) ? TYPE_SECTION : TYPE_KEY, at,
				level_token[(depth == 0) ? 0 : depth - 1]);
			last_head_index = fresh;
			if (open_index >= token_cap) begin
				push_rec(KIND_NO_TOKENS, open_index, TYPE_SECTION, '0, '0, '0);
				halted = 1;
				return;
			end
		end
		if (b == CH_TAB || b == CH_LF) begin
			depth = was_run ? tab_depth : 0;
			if (b == CH_TAB && depth < DEPTH_LEVELS)
				depth++;
			tab_depth = depth;
			in_separator_run = 1;
		end else if (b == CH_NUL) begin
			push_rec(KIND_TOKEN, open_index, open_type, open_start, {1'b0, at} - 17'd1,
				open_parent);
			push_rec((open_index >= token_cap) ? KIND_NO_TOKENS : KIND_DONE, open_index,
				TYPE_SECTION, '0, '0, '0);
			halted = 1;
			return;
		end else begin
			last_plain_pos = {1'b0, at};
			if (b == CH_SPACE) begin
				push_rec(KIND_TOKEN, open_index, open_type, open_start, {1'b0, at} - 17'd1,
					open_parent);
				open_new_token(TYPE_VALUE, at + 16'd1, last_head_index);
			end
			if (open_index >= token_cap) begin
				push_rec(KIND_NO_TOKENS, open_index, TYPE_SECTION, '0, '0, '0);
				halted = 1;
				return;
			end
		end
		doc_pos = at + 16'd1;
	endfunction

	task automatic check_record();
		token_rec_t want;
		records_checked++;
		if (m_tuser == KIND_TOKEN)
			tokens_closed++;
		if (expected_records.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected record: kind %0d tdata %h last %b", m_tuser, m_tdata,
					m_tlast);
		end else begin
			want = expected_records.pop_front();
			if (m_tuser !== want.kind || m_tdata[15:0] !== want.tok_index ||
					m_tdata[17:16] !== want.tok_type || m_tdata[33:18] !== want.first_pos ||
					m_tdata[50:34] !== want.last_pos || m_tdata[66:51] !== want.parent_idx ||
					m_tlast !== want.is_last) begin
				fails++;
				if (fails <= 10) begin
					$display("record %0d expected kind %0d idx %0d type %0d start %0d end %h par %0d last %b",
						records_checked, want.kind, want.tok_index, want.tok_type,
						want.first_pos, want.last_pos, want.parent_idx, want.is_last);
					$display("record %0d got      kind %0d idx %0d type %0d start %0d end %h par %0d last %b",
						records_checked, m_tuser, m_tdata[15:0], m_tdata[17:16],
						m_tdata[33:18], m_tdata[50:34], m_tdata[66:51], m_tlast);
				end
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tokenize_byte(b);
		if (step_count > 0)
			step_out[step_count - 1].is_last = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_records.push_back(step_out[i]);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (expected_records.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_token_limit(input logic [15:0] value);
		wait_for_drain();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		token_cap = value;
	endtask

	function automatic logic [7:0] word_char();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	task automatic send_line();
		int tabs;
		int room;
		int n;
		send_byte(CH_LF);
		if ($urandom_range(0, 9) == 0)
			send_byte(CH_LF);
		tabs = $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0)
			tabs = $urandom_range(4, DEPTH_LEVELS - 1);
		room = DEPTH_LEVELS - 1 - (in_separator_run ? tab_depth : 0);
		if (tabs > room)
			tabs = room;
		repeat (tabs) send_byte(CH_TAB);
		if ($urandom_range(0, 2) == 0)
			send_byte(CH_UNDER);
		else
			send_byte(8'($urandom_range(8'h61, 8'h7A)));
		n = $urandom_range(0, 5);
		repeat (n) send_byte(word_char());
		while ($urandom_range(0, 1) == 1) begin
			send_byte(CH_SPACE);
			n = $urandom_range(0, 6);
			repeat (n) send_byte(word_char());
		end
	endtask

	// raw bytes, tab runs kept below the indent limit
	task automatic send_noise(input int count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom_range(1, 255));
			if (b == CH_TAB && in_separator_run && tab_depth >= DEPTH_LEVELS - 2)
				b = CH_LF;
			send_byte(b);
		end
	endtask

	task automatic test_config_low_limit();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		set_token_limit(16'd1);
		send_byte("a");
		send_byte("b");
	endtask

	task automatic test_directed_document();
		logic [7:0] doc [$];
		doc = '{CH_SPACE, CH_SPACE, "v", CH_LF, CH_TAB, CH_UNDER, "s", CH_LF, CH_TAB, CH_TAB,
			CH_LF, "k", CH_SPACE, CH_LF, CH_SPACE, "x", CH_TAB, "y", 8'hFF, 8'h80, CH_LF,
			CH_TAB, "q"};
		set_token_limit(LIMIT_RESET);
		foreach (doc[i])
			send_byte(doc[i]);
	endtask

	task automatic test_random_document(input int idle, input int stall, input int quota,
			input bit full_limit);
		int stop_at;
		if (full_limit)
			set_token_limit(LIMIT_RESET);
		else
			set_token_limit(16'(open_index + 300 + $urandom_range(0, 2000)));
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		stop_at = bytes_sent + quota;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				send_noise($urandom_range(1, 6));
			else
				send_line();
		end
	endtask

	task automatic test_document_end();
		end_case = $urandom_range(0, 6);
		case (end_case)
			0: send_byte(CH_NUL);
			1: begin
				send_byte(CH_LF);
				send_byte(CH_TAB);
				send_byte(CH_NUL);
			end
			2: begin
				set_token_limit(open_index);
				send_byte(CH_NUL);
			end
			3: begin
				set_token_limit(open_index + 16'd1);
				send_byte(CH_LF);
				send_byte(CH_UNDER);
			end
			4: begin
				send_byte(CH_LF);
				repeat ($urandom_range(DEPTH_LEVELS, DEPTH_LEVELS + 4)) send_byte(CH_TAB);
				send_byte("k");
			end
			5: begin
				set_token_limit(open_index + 16'd1);
				send_byte(CH_SPACE);
			end
			default: begin
				set_token_limit(open_index);
				send_byte("q");
			end
		endcase
		// block is stopped, these must produce nothing
		repeat (8) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		reset_tokenizer_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_config_low_limit();
		test_directed_document();
		test_random_document(0, 0, 110, 1'b1);
		test_random_document(83, 0, 110, 1'b0);
		test_random_document(0, 83, 110, 1'b0);
		test_random_document(10, 10, 110, 1'b0);
		test_document_end();

		wait_for_drain();
		repeat (20) @(negedge clk);
		fails += expected_records.size();
		$display("sent %0d bytes, checked %0d records (%0d closed tokens), %0d mismatches",
			bytes_sent, records_checked, tokens_closed, fails);
		$display("limits 1 and 65535 and random, four idle mixes, document end case %0d",
			end_case);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
